[hw/rtl/psma_pkg.sv]
// Package with the shared constants, types and arithmetic helpers of the power-sum accumulator.
package psma_pkg;

    // Number of channels and of powers kept per channel.
    localparam int CHANNELS   = 64;
    localparam int MAX_POWERS = 8;

    // One cell per power; at most eight powers can be reported.
    localparam int NCELLS = (MAX_POWERS < 8) ? MAX_POWERS : 8;
    localparam int CH_AW  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    // Field widths.
    localparam int VALUE_W = 32;
    localparam int SUM_W   = 64;
    localparam int CNT_W   = 20;
    localparam int CHAN_W  = 6;
    localparam int PIDX_W  = 3;
    localparam int NPOW_W  = 4;
    localparam int CFG_IW  = 2;
    localparam int CFG_DW  = 20;

    // Configuration register indexes.
    localparam logic [CFG_IW-1:0] REG_POWER_COUNT = 2'd0;
    localparam logic [CFG_IW-1:0] REG_BURN_IN     = 2'd1;
    localparam logic [CFG_IW-1:0] REG_MAX_SAMPLES = 2'd2;

    // Function codes of an input item.
    localparam logic FUNC_ACCUMULATE = 1'b0;
    localparam logic FUNC_READOUT    = 1'b1;

    // Token that walks down the cell chain: current power, the value and the row.
    typedef struct packed {
        logic                go;
        logic [VALUE_W-1:0]  p;
        logic [VALUE_W-1:0]  v;
        logic [CH_AW-1:0]    addr;
    } psma_tok_t;

    // Control broadcast from the sequencer to every cell.
    typedef struct packed {
        logic             clr;
        logic             rd;
        logic             load;
        logic             shift;
        logic [CH_AW-1:0] addr;
    } psma_ctl_t;

    // Divide a Q32.32 product by 65536 rounding half up, then saturate to 32 bits.
    function automatic logic [VALUE_W-1:0] round_q16(input logic signed [SUM_W-1:0] prod);
        logic signed [SUM_W-1:0] x;
        logic signed [SUM_W-1:0] q;
        logic [VALUE_W-1:0]      r;
        x = prod + 64'sd32768;
        q = x >>> 16;
        if (q[SUM_W-1:VALUE_W-1] == '0 || q[SUM_W-1:VALUE_W-1] == '1)
        begin
            r = q[VALUE_W-1:0];
        end
        else if (q[SUM_W-1])
        begin
            r = 32'h8000_0000;
        end
        else
        begin
            r = 32'h7FFF_FFFF;
        end
        return r;
    endfunction

    // Signed 64-bit addition of a sign-extended 32-bit term, saturating.
    function automatic logic [SUM_W-1:0] sat_add64(input logic [SUM_W-1:0] a,
                                                   input logic [VALUE_W-1:0] b);
        logic [SUM_W-1:0] bx;
        logic [SUM_W-1:0] s;
        logic [SUM_W-1:0] r;
        bx = {{(SUM_W-VALUE_W){b[VALUE_W-1]}}, b};
        s  = a + bx;
        if (a[SUM_W-1] == bx[SUM_W-1] && s[SUM_W-1] != a[SUM_W-1])
        begin
            r = a[SUM_W-1] ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
        end
        else
        begin
            r = s;
        end
        return r;
    endfunction

endpackage

[hw/rtl/psma_in_if.sv]
// Interface of the input channel carrying measurements and readout requests.
interface psma_in_if;
    logic                                 valid;
    logic                                 ready;
    logic                                 func;
    logic signed [psma_pkg::VALUE_W-1:0]  value;
    logic [psma_pkg::CHAN_W-1:0]          channel;
    logic                                 end_of_sample;

    modport source (output valid, func, value, channel, end_of_sample, input ready);
    modport sink   (input valid, func, value, channel, end_of_sample, output ready);
endinterface

[hw/rtl/psma_out_if.sv]
// Interface of the result channel carrying the power sums.
interface psma_out_if;
    logic                                valid;
    logic                                ready;
    logic [psma_pkg::PIDX_W-1:0]         power_index;
    logic signed [psma_pkg::SUM_W-1:0]   power_sum;
    logic [psma_pkg::CNT_W-1:0]          sample_total;
    logic                                last;

    modport source (output valid, power_index, power_sum, sample_total, last, input ready);
    modport sink   (input valid, power_index, power_sum, sample_total, last, output ready);
endinterface

[hw/rtl/psma_cfg_if.sv]
// Interface of the configuration write channel.
interface psma_cfg_if;
    logic                          valid;
    logic                          ready;
    logic [psma_pkg::CFG_IW-1:0]   index;
    logic [psma_pkg::CFG_DW-1:0]   data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

[hw/rtl/psma_cell.sv]
// One cell of the chain: the sums of one power for every channel, plus the next-power multiply.
module psma_cell (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cell_on,
    input  psma_pkg::psma_ctl_t           ctl,
    input  psma_pkg::psma_tok_t           tok_in,
    output psma_pkg::psma_tok_t           tok_out,
    input  logic [psma_pkg::SUM_W-1:0]    hold_in,
    output logic [psma_pkg::SUM_W-1:0]    hold_out
);

    // Sum memory of this power, one row per channel.
    logic [psma_pkg::SUM_W-1:0] mem [psma_pkg::CHANNELS];

    logic [psma_pkg::SUM_W-1:0]    rd_data_reg;
    logic [psma_pkg::CH_AW-1:0]    rd_addr;
    logic signed [psma_pkg::SUM_W-1:0] prod_reg;
    logic                          a_go_reg;
    logic [psma_pkg::VALUE_W-1:0]  a_p_reg;
    logic [psma_pkg::VALUE_W-1:0]  a_v_reg;
    logic [psma_pkg::CH_AW-1:0]    a_addr_reg;
    logic [psma_pkg::SUM_W-1:0]    sum_next;
    psma_pkg::psma_tok_t           tok_out_reg;
    logic [psma_pkg::SUM_W-1:0]    hold_reg;

    // The readout shares the read port with the arriving token.
    assign rd_addr = ctl.rd ? ctl.addr : tok_in.addr;

    // Registered memory read.
    always_ff @(posedge clk)
    begin
        rd_data_reg <= mem[rd_addr];
    end

    // First stage: capture the token and form the exact product for the next power.
    always_ff @(posedge clk)
    begin
        prod_reg   <= $signed(tok_in.p) * $signed(tok_in.v);
        a_p_reg    <= tok_in.p;
        a_v_reg    <= tok_in.v;
        a_addr_reg <= tok_in.addr;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_go_reg <= 1'b0;
        end
        else
        begin
            a_go_reg <= tok_in.go;
        end
    end

    // Second stage: saturating add into the stored sum.
    assign sum_next = psma_pkg::sat_add64(rd_data_reg, a_p_reg);

    // Single write port: clearing pass or accumulate write-back.
    always_ff @(posedge clk)
    begin
        if (ctl.clr)
        begin
            mem[ctl.addr] <= '0;
        end
        else if (a_go_reg && cell_on)
        begin
            mem[a_addr_reg] <= sum_next;
        end
    end

    // Hand the rounded next power to the neighbouring cell.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok_out_reg <= '0;
        end
        else
        begin
            tok_out_reg.go   <= a_go_reg;
            tok_out_reg.p    <= psma_pkg::round_q16(prod_reg);
            tok_out_reg.v    <= a_v_reg;
            tok_out_reg.addr <= a_addr_reg;
        end
    end

    // Readout hold register, shifted towards cell zero on each result transfer.
    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            hold_reg <= rd_data_reg;
        end
        else if (ctl.shift)
        begin
            hold_reg <= hold_in;
        end
    end

    assign tok_out  = tok_out_reg;
    assign hold_out = hold_reg;

endmodule

[hw/rtl/power_sum_moment_accumulator_unit.sv]
// Top level of the power-sum moment accumulator: sequencer, configuration and the cell chain.
// An accumulate item with n active powers passes from its transfer through each active cell in
// turn, each cell doing a memory read and multiply, then write-back and rounding, and the
// sequencer then returns to idle; no new item is taken until then.
// A readout reads the row and loads the hold registers, then gives n results, one per cycle
// while the result receiver is ready. Ignored accumulate items leave the sequencer idle.
// After reset a clearing pass zeroes the sums of every channel; no item is taken meanwhile.
module power_sum_moment_accumulator_unit (
    input  logic          clk,
    input  logic          rst_n,
    psma_in_if.sink       sample,
    psma_out_if.source    result,
    psma_cfg_if.sink      cfg
);

    // Sequencer states.
    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_ACC   = 3'd2;
    localparam logic [2:0] S_RD    = 3'd3;
    localparam logic [2:0] S_LOAD  = 3'd4;
    localparam logic [2:0] S_OUT   = 3'd5;

    logic [2:0]                     state_reg, state_next;
    logic [psma_pkg::NPOW_W-1:0]    power_count_reg;
    logic [psma_pkg::CNT_W-1:0]     burn_in_reg;
    logic [psma_pkg::CNT_W-1:0]     max_samples_reg;
    logic [psma_pkg::CNT_W-1:0]     counter_reg, counter_next;
    logic [psma_pkg::CH_AW-1:0]     clr_addr_reg, clr_addr_next;
    logic [psma_pkg::CH_AW-1:0]     addr_reg, addr_next;
    logic                           ro_ok_reg, ro_ok_next;
    logic [psma_pkg::PIDX_W-1:0]    k_reg, k_next;
    psma_pkg::psma_tok_t            tok0_reg, tok0_next;
    logic [psma_pkg::NPOW_W-1:0]    n_act;
    logic                           in_xfer;
    logic                           out_xfer;
    logic                           ch_ok;
    logic                           is_last;
    logic                           done;
    psma_pkg::psma_ctl_t            ctl;

    psma_pkg::psma_tok_t            tok   [psma_pkg::NCELLS+1];
    logic [psma_pkg::SUM_W-1:0]     hold  [psma_pkg::NCELLS+1];
    logic [psma_pkg::NCELLS:0]      go_vec;
    logic [psma_pkg::NCELLS-1:0]    cell_on;

    assign in_xfer  = sample.valid && sample.ready;
    assign out_xfer = result.valid && result.ready;
    assign ch_ok    = 32'(sample.channel) < psma_pkg::CHANNELS;

    // Active power count: zero counts as one, clamp to the number of cells.
    always_comb
    begin
        if (power_count_reg == '0)
        begin
            n_act = 4'd1;
        end
        else if (32'(power_count_reg) > psma_pkg::NCELLS)
        begin
            n_act = psma_pkg::NPOW_W'(psma_pkg::NCELLS);
        end
        else
        begin
            n_act = power_count_reg;
        end
    end

    // Configuration registers; the channel always takes a transfer.
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            power_count_reg <= 4'd4;
            burn_in_reg     <= '0;
            max_samples_reg <= '1;
        end
        else if (cfg.valid && cfg.ready)
        begin
            case (cfg.index)
                psma_pkg::REG_POWER_COUNT: power_count_reg <= cfg.data[psma_pkg::NPOW_W-1:0];
                psma_pkg::REG_BURN_IN:     burn_in_reg     <= cfg.data;
                psma_pkg::REG_MAX_SAMPLES: max_samples_reg <= cfg.data;
                default:                   ;
            endcase
        end
    end

    // Token arriving at the end of the active part of the chain.
    always_comb
    begin
        done = 1'b0;
        for (int k = 0; k <= psma_pkg::NCELLS; k++)
        begin
            if (go_vec[k] && 32'(n_act) == k)
            begin
                done = 1'b1;
            end
        end
    end

    assign is_last = (4'(k_reg) + 4'd1) == n_act;

    // Sequencer.
    always_comb
    begin
        state_next    = state_reg;
        counter_next  = counter_reg;
        clr_addr_next = clr_addr_reg;
        addr_next     = addr_reg;
        ro_ok_next    = ro_ok_reg;
        k_next        = k_reg;
        tok0_next     = tok0_reg;
        tok0_next.go  = 1'b0;
        ctl           = '0;
        ctl.addr      = addr_reg;

        case (state_reg)
            S_CLEAR:
            begin
                ctl.clr       = 1'b1;
                ctl.addr      = clr_addr_reg;
                clr_addr_next = clr_addr_reg + psma_pkg::CH_AW'(1);
                if (clr_addr_reg == psma_pkg::CH_AW'(psma_pkg::CHANNELS - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_xfer)
                begin
                    addr_next  = psma_pkg::CH_AW'(sample.channel);
                    ro_ok_next = ch_ok;
                    if (sample.func == psma_pkg::FUNC_READOUT)
                    begin
                        k_next     = '0;
                        state_next = S_RD;
                    end
                    else if (counter_reg < max_samples_reg)
                    begin
                        if (sample.end_of_sample)
                        begin
                            counter_next = counter_reg + psma_pkg::CNT_W'(1);
                        end
                        if (counter_reg >= burn_in_reg && ch_ok)
                        begin
                            tok0_next.go   = 1'b1;
                            tok0_next.p    = sample.value;
                            tok0_next.v    = sample.value;
                            tok0_next.addr = psma_pkg::CH_AW'(sample.channel);
                            state_next     = S_ACC;
                        end
                    end
                end
            end
            S_ACC:
            begin
                if (done)
                begin
                    state_next = S_IDLE;
                end
            end
            S_RD:
            begin
                ctl.rd     = 1'b1;
                state_next = S_LOAD;
            end
            S_LOAD:
            begin
                ctl.load   = 1'b1;
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (out_xfer)
                begin
                    ctl.shift = 1'b1;
                    k_next    = k_reg + psma_pkg::PIDX_W'(1);
                    if (is_last)
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_CLEAR;
            counter_reg  <= '0;
            clr_addr_reg <= '0;
            tok0_reg     <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            counter_reg  <= counter_next;
            clr_addr_reg <= clr_addr_next;
            tok0_reg     <= tok0_next;
        end
    end

    always_ff @(posedge clk)
    begin
        addr_reg      <= addr_next;
        ro_ok_reg     <= ro_ok_next;
        k_reg         <= k_next;
    end

    // Cell chain, one cell per power.
    assign tok[0]                   = tok0_reg;
    assign hold[psma_pkg::NCELLS]   = '0;
    assign go_vec[0]                = tok0_reg.go;

    for (genvar g = 0; g < psma_pkg::NCELLS; g++)
    begin : g_cell
        assign cell_on[g]  = 32'(n_act) > g;
        assign go_vec[g+1] = tok[g+1].go;

        psma_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .cell_on  (cell_on[g]),
            .ctl      (ctl),
            .tok_in   (tok[g]),
            .tok_out  (tok[g+1]),
            .hold_in  (hold[g+1]),
            .hold_out (hold[g])
        );
    end

    // Handshake and result payload.
    assign sample.ready        = state_reg == S_IDLE;
    assign result.valid        = state_reg == S_OUT;
    assign result.power_index  = k_reg;
    assign result.power_sum    = ro_ok_reg ? hold[0] : '0;
    assign result.sample_total = counter_reg;
    assign result.last         = is_last;

    // Input and result sides are never open together.
    assert property (@(posedge clk) disable iff (!rst_n)
        !(sample.ready && result.valid))
        else $error("input ready while a result is pending");

    // The final result of a readout returns the block to idle.
    assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && result.ready && result.last) |=> sample.ready)
        else $error("block not idle after last result");

    // Result index stays below the active power count.
    assert property (@(posedge clk) disable iff (!rst_n)
        result.valid |-> (4'(result.power_index) < n_act))
        else $error("power index beyond active powers");

endmodule

[tb/tb.sv]
// Self-checking testbench of the power-sum moment accumulator unit.
`timescale 1ns / 100ps

module tb;

    import psma_pkg::*;

    localparam realtime CLK_PERIOD   = 12ns;
    localparam int      RESET_CYCLES = 12;
    localparam int      SETTLE_CYCLES = 4 * MAX_POWERS + 8;
    localparam int      HOLD_CYCLES  = 400;
    localparam int      CYCLE_LIMIT  = 200000;
    localparam int      REPORT_LIMIT = 10;

    // One input transfer: a measurement or a readout request.
    typedef struct packed {
        logic                      func;
        logic signed [VALUE_W-1:0] value;
        logic [CHAN_W-1:0]         channel;
        logic                      eos;
    } reading_t;

    // One result transfer: a single power sum of a channel.
    typedef struct packed {
        logic [PIDX_W-1:0]       idx;
        logic signed [SUM_W-1:0] sum;
        logic [CNT_W-1:0]        total;
        logic                    last;
    } moment_t;

    logic clk = 1'b0;
    logic rst_n;

    psma_in_if  sample_bus ();
    psma_out_if sum_bus ();
    psma_cfg_if cfg_bus ();

    power_sum_moment_accumulator_unit dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .sample (sample_bus),
        .result (sum_bus),
        .cfg    (cfg_bus)
    );

    // Stimulus and expectation stores.
    reading_t pending_readings[$];
    moment_t  expected_moments[$];
    int       readings_accepted = 0;
    int       readings_popped = 0;
    bit       offering = 1'b0;
    int       send_idle_pct = 0;
    int       recv_stall_pct = 0;
    int       holds_requested = 0;
    int       holds_granted = 0;
    int       hold_left = 0;
    int       mismatches = 0;
    int       cycle_count = 0;

    // Predicted state of the block and its registers.
    logic signed [SUM_W-1:0] sums_model [CHANNELS][MAX_POWERS];
    logic [CNT_W-1:0]        sample_count_model;
    logic [NPOW_W-1:0]       power_count_reg;
    logic [CNT_W-1:0]        burn_in_reg;
    logic [CNT_W-1:0]        max_samples_reg;

    always #(CLK_PERIOD / 2) clk = ~clk;

    // Q32.32 product back to Q16.16, rounding half up and saturating to 32 bits.
    function automatic logic signed [VALUE_W-1:0] rescale_q16(input logic signed [SUM_W-1:0] prod);
        logic signed [SUM_W-1:0] q;
        q = (prod + 64'sd32768) >>> 16;
        if (q > 64'sd2147483647)
        begin
            return 32'sh7FFF_FFFF;
        end
        if (q < -64'sd2147483648)
        begin
            return 32'sh8000_0000;
        end
        return q[VALUE_W-1:0];
    endfunction

    // Running sum plus one power, clipped at the signed 64-bit limits.
    function automatic logic signed [SUM_W-1:0] add_saturated(input logic signed [SUM_W-1:0] acc,
                                                              input logic signed [VALUE_W-1:0] term);
        logic signed [SUM_W:0] wide;
        wide = acc + term;
        if (wide[SUM_W] != wide[SUM_W-1])
        begin
            return wide[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
        end
        return wide[SUM_W-1:0];
    endfunction

    // Power count in effect: zero acts as one, large values clamp.
    function automatic int active_power_count();
        int n;
        n = int'(power_count_reg);
        if (n < 1)
        begin
            n = 1;
        end
        if (n > MAX_POWERS)
        begin
            n = MAX_POWERS;
        end
        if (n > 8)
        begin
            n = 8;
        end
        return n;
    endfunction

    // Update the predicted sums for one accepted transfer and queue any readout results.
    task automatic predict_reading(input reading_t rd);
        int                        n;
        logic signed [VALUE_W-1:0] pw;
        logic signed [SUM_W-1:0]   prod;
        moment_t                   m;
        n = active_power_count();
        if (rd.func == FUNC_ACCUMULATE)
        begin
            // Past the sample limit the whole item is dropped.
            if (sample_count_model < max_samples_reg)
            begin
                if (sample_count_model >= burn_in_reg && rd.channel < CHANNELS)
                begin
                    pw = rd.value;
                    for (int k = 0; k < n; k++)
                    begin
                        sums_model[rd.channel][k] = add_saturated(sums_model[rd.channel][k], pw);
                        prod = pw;
                        prod = prod * $signed(rd.value);
                        pw = rescale_q16(prod);
                    end
                end
                if (rd.eos)
                begin
                    sample_count_model = sample_count_model + CNT_W'(1);
                end
            end
        end
        else
        begin
            for (int k = 0; k < n; k++)
            begin
                m.idx   = PIDX_W'(k);
                m.sum   = (rd.channel < CHANNELS) ? sums_model[rd.channel][k] : '0;
                m.total = sample_count_model;
                m.last  = (k == n - 1);
                expected_moments = {expected_moments, m};
            end
        end
    endtask

    // Compare one result transfer with the oldest expectation.
    task automatic check_moment(input moment_t got);
        moment_t want;
        if (expected_moments.size() == 0)
        begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
            begin
                $display("unexpected result: index %0d sum %0d total %0d last %0b",
                         got.idx, $signed(got.sum), got.total, got.last);
            end
        end
        else
        begin
            want = expected_moments.pop_front();
            if (got.idx !== want.idx || got.sum !== want.sum || got.total !== want.total ||
                got.last !== want.last)
            begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                begin
                    $display("result mismatch: expected index %0d sum %0d total %0d last %0b",
                             want.idx, $signed(want.sum), want.total, want.last);
                    $display("                 got      index %0d sum %0d total %0d last %0b",
                             got.idx, $signed(got.sum), got.total, got.last);
                end
            end
        end
    endtask

    // Monitor: checks results, tracks register writes and predicts from accepted inputs.
    always @(posedge clk)
    begin : monitor
        moment_t  got;
        reading_t seen;
        if (!rst_n)
        begin
            foreach (sums_model[c, k])
            begin
                sums_model[c][k] = '0;
            end
            sample_count_model = '0;
            power_count_reg    = 4'd4;
            burn_in_reg        = '0;
            max_samples_reg    = '1;
        end
        else
        begin
            if (sum_bus.valid && sum_bus.ready)
            begin
                got.idx   = sum_bus.power_index;
                got.sum   = sum_bus.power_sum;
                got.total = sum_bus.sample_total;
                got.last  = sum_bus.last;
                check_moment(got);
            end
            if (cfg_bus.valid && cfg_bus.ready)
            begin
                case (cfg_bus.index)
                    REG_POWER_COUNT: power_count_reg = cfg_bus.data[NPOW_W-1:0];
                    REG_BURN_IN:     burn_in_reg     = cfg_bus.data[CNT_W-1:0];
                    REG_MAX_SAMPLES: max_samples_reg = cfg_bus.data[CNT_W-1:0];
                    default:         ;
                endcase
            end
            if (sample_bus.valid && sample_bus.ready)
            begin
                seen.func    = sample_bus.func;
                seen.value   = sample_bus.value;
                seen.channel = sample_bus.channel;
                seen.eos     = sample_bus.end_of_sample;
                predict_reading(seen);
                readings_accepted++;
            end
        end
    end

    // Input driver: offers the head of the pending queue and holds it until the transfer.
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            sample_bus.valid <= 1'b0;
        end
        else
        begin
            if (readings_popped != readings_accepted)
            begin
                void'(pending_readings.pop_front());
                readings_popped++;
                offering = 1'b0;
            end
            if (!offering && pending_readings.size() != 0 &&
                $urandom_range(99) >= send_idle_pct)
            begin
                offering = 1'b1;
            end
            sample_bus.valid <= offering;
            if (offering)
            begin
                sample_bus.func          <= pending_readings[0].func;
                sample_bus.value         <= pending_readings[0].value;
                sample_bus.channel       <= pending_readings[0].channel;
                sample_bus.end_of_sample <= pending_readings[0].eos;
            end
        end
    end

    // Result ready: random stalls, or a long hold-off when one is requested.
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            sum_bus.ready <= 1'b0;
        end
        else if (holds_granted != holds_requested)
        begin
            holds_granted++;
            hold_left = HOLD_CYCLES;
            sum_bus.ready <= 1'b0;
        end
        else if (hold_left > 0)
        begin
            hold_left--;
            sum_bus.ready <= 1'b0;
        end
        else
        begin
            sum_bus.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Watchdog on the total run length.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("tb NOT OK");
            $finish;
        end
    end

    task automatic write_register(input logic [CFG_IW-1:0] idx, input logic [CFG_DW-1:0] data);
        @(negedge clk);
        cfg_bus.valid <= 1'b1;
        cfg_bus.index <= idx;
        cfg_bus.data  <= data;
        do
        begin
            @(posedge clk);
        end
        while (!(cfg_bus.valid && cfg_bus.ready));
        @(negedge clk);
        cfg_bus.valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic queue_reading(input logic func, input logic signed [VALUE_W-1:0] value,
                                 input logic [CHAN_W-1:0] channel, input logic eos);
        reading_t rd;
        rd.func    = func;
        rd.value   = value;
        rd.channel = channel;
        rd.eos     = eos;
        pending_readings = {pending_readings, rd};
    endtask

    // Mix of full-range, small, mid-range and extreme measurements.
    function automatic logic signed [VALUE_W-1:0] random_value();
        case ($urandom_range(3))
            0: return $urandom;
            1: return $urandom_range(32'h3FFFF) - 32'h20000;
            2: return $urandom_range(32'h1FF_FFFF) - 32'h100_0000;
            default:
            begin
                case ($urandom_range(4))
                    0: return 32'sh7FFF_FFFF;
                    1: return 32'sh8000_0000;
                    2: return 32'sh0000_0000;
                    3: return 32'shFFFF_FFFF;
                    default: return 32'sh0000_8000;
                endcase
            end
        endcase
    endfunction

    task automatic queue_random(input int count, input int readout_pct);
        reading_t rd;
        repeat (count)
        begin
            rd.func    = ($urandom_range(99) < readout_pct) ? FUNC_READOUT : FUNC_ACCUMULATE;
            rd.value   = random_value();
            rd.channel = $urandom_range(1) ? CHAN_W'($urandom_range(3)) :
                                             CHAN_W'($urandom_range(CHANNELS - 1));
            rd.eos     = ($urandom_range(3) == 0);
            pending_readings = {pending_readings, rd};
        end
    endtask

    // Wait until every input is taken and every result is in, then let the pipeline drain.
    task automatic settle();
        while (pending_readings.size() != 0 || expected_moments.size() != 0)
        begin
            @(negedge clk);
        end
        repeat (SETTLE_CYCLES) @(negedge clk);
        @(posedge clk);
    endtask

    // Test sequence.
    initial
    begin
        rst_n = 1'b0;
        sample_bus.valid = 1'b0;
        sample_bus.func = FUNC_ACCUMULATE;
        sample_bus.value = '0;
        sample_bus.channel = '0;
        sample_bus.end_of_sample = 1'b0;
        sum_bus.ready = 1'b0;
        cfg_bus.valid = 1'b0;
        cfg_bus.index = REG_POWER_COUNT;
        cfg_bus.data = '0;
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(posedge clk);

        // Cleared store and reset register values.
        queue_reading(FUNC_READOUT, 32'sh0, 6'd0, 1'b1);
        queue_reading(FUNC_READOUT, 32'sh0, 6'd63, 1'b0);
        queue_reading(FUNC_ACCUMULATE, 32'sh0001_8000, 6'd7, 1'b0);
        queue_reading(FUNC_READOUT, 32'sh0, 6'd7, 1'b0);
        settle();

        // Directed extremes with all eight powers.
        write_register(REG_POWER_COUNT, 20'd8);
        write_register(REG_BURN_IN, 20'd0);
        write_register(REG_MAX_SAMPLES, 20'hFFFFF);
        queue_reading(FUNC_ACCUMULATE, 32'sh7FFF_FFFF, 6'd0, 1'b0);
        queue_reading(FUNC_ACCUMULATE, 32'sh8000_0000, 6'd63, 1'b0);
        queue_reading(FUNC_ACCUMULATE, 32'sh0001_0000, 6'd1, 1'b0);
        queue_reading(FUNC_ACCUMULATE, 32'shFFFF_0000, 6'd2, 1'b0);
        queue_reading(FUNC_ACCUMULATE, 32'sh0000_8000, 6'd3, 1'b0);
        queue_reading(FUNC_ACCUMULATE, 32'shFFFF_8000, 6'd3, 1'b0);
        queue_reading(FUNC_ACCUMULATE, 32'sh0000_0001, 6'd4, 1'b0);
        queue_reading(FUNC_ACCUMULATE, 32'shFFFF_FFFF, 6'd4, 1'b1);
        queue_reading(FUNC_ACCUMULATE, 32'sh0001_8000, 6'd5, 1'b1);
        queue_reading(FUNC_READOUT, 32'sh0, 6'd0, 1'b0);
        queue_reading(FUNC_READOUT, 32'sh0, 6'd63, 1'b1);
        queue_reading(FUNC_READOUT, 32'sh0, 6'd1, 1'b0);
        queue_reading(FUNC_READOUT, 32'sh0, 6'd2, 1'b0);
        queue_reading(FUNC_READOUT, 32'sh0, 6'd3, 1'b1);
        queue_reading(FUNC_READOUT, 32'sh0, 6'd4, 1'b0);
        queue_reading(FUNC_READOUT, 32'sh0, 6'd5, 1'b0);
        settle();

        // Single power, no idling on either side.
        send_idle_pct = 0;
        recv_stall_pct = 0;
        write_register(REG_POWER_COUNT, 20'd1);
        queue_random(50, 25);
        settle();

        // A power count of zero acts as one; the burn-in ends a few samples ahead.
        write_register(REG_POWER_COUNT, 20'd0);
        write_register(REG_BURN_IN, 20'(sample_count_model + 4));
        send_idle_pct = 71;
        recv_stall_pct = 0;
        queue_random(40, 25);
        settle();

        // Oversized power count clamps; the sample limit is hit part-way through.
        write_register(REG_POWER_COUNT, 20'd15);
        write_register(REG_BURN_IN, 20'd0);
        write_register(REG_MAX_SAMPLES, 20'(sample_count_model + 6));
        send_idle_pct = 0;
        recv_stall_pct = 71;
        queue_random(50, 25);
        settle();

        // Register extremes: nothing may be accumulated.
        write_register(REG_POWER_COUNT, 20'd5);
        write_register(REG_BURN_IN, 20'hFFFFF);
        write_register(REG_MAX_SAMPLES, 20'd0);
        send_idle_pct = 34;
        recv_stall_pct = 34;
        queue_random(20, 30);
        settle();

        // Long receiver hold-off while readouts keep coming, so the input backs up.
        write_register(REG_MAX_SAMPLES, 20'hFFFFF);
        write_register(REG_BURN_IN, 20'd0);
        write_register(REG_POWER_COUNT, 20'd8);
        send_idle_pct = 0;
        recv_stall_pct = 0;
        holds_requested++;
        queue_random(40, 60);
        settle();

        // Intermediate power count with idling on both sides.
        write_register(REG_POWER_COUNT, 20'($urandom_range(7, 2)));
        send_idle_pct = 34;
        recv_stall_pct = 34;
        queue_random(60, 25);
        settle();

        @(negedge clk);
        if (mismatches == 0 && expected_moments.size() == 0)
        begin
            $display("tb OK");
        end
        else
        begin
            $display("tb NOT OK");
        end
        $finish;
    end

endmodule
